// File: hdl/wpc_pkg.sv
package wpc_pkg;

  // controller modes, encoded as the host sees them
  typedef enum logic [2:0] {
    MODE_RUN         = 3'd0,
    MODE_PRESSED     = 3'd1,
    MODE_BLINK       = 3'd2,
    MODE_OFF         = 3'd3,
    MODE_OFF_HOLD    = 3'd4,
    MODE_REBOOT      = 3'd5,
    MODE_REBOOT_HOLD = 3'd6
  } mode_t;

  // configuration register indexes
  localparam logic [2:0] CFG_LONG_PRESS  = 3'd0;
  localparam logic [2:0] CFG_WD_UNIT     = 3'd1;
  localparam logic [2:0] CFG_REBOOT_UNIT = 3'd2;
  localparam logic [2:0] CFG_WAKE_HOLD   = 3'd3;
  localparam logic [2:0] CFG_BLINK_HALF  = 3'd4;

  // configuration reset values
  localparam logic [15:0] LONG_PRESS_RST  = 16'd75;
  localparam logic [7:0]  WD_UNIT_RST     = 8'd25;
  localparam logic [7:0]  REBOOT_UNIT_RST = 8'd50;
  localparam logic [7:0]  WAKE_HOLD_RST   = 8'd12;
  localparam logic [7:0]  BLINK_HALF_RST  = 8'd3;

  // status bits
  localparam logic [2:0] ST_SHORT  = 3'b001;
  localparam logic [2:0] ST_BUTTON = 3'b010;
  localparam logic [2:0] ST_TIMER  = 3'b100;

  // slow reboot blink: lit when tick bits 5:3 read 110
  localparam logic [7:0] LED_PHASE_MASK = 8'h38;
  localparam logic [7:0] LED_PHASE_ON   = 8'h30;

  localparam logic [7:0] DELAY_MAX = 8'hFF;

endpackage

// File: hdl/watchdog_power_controller_unit.sv
// channel | direction | handshake             | payload
// --------+-----------+-----------------------+--------------------------------------------
// in_     | input     | in_valid / in_ready   | button level, host write/read, new settings
// out_    | output    | out_valid / out_ready | power, led, status, settings, mode
// cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one request per clock while in_ready is high: a tick item is folded into the state in
// the cycle it is accepted, and its result is registered in the output register (in the
// skid register if the output is stalled); the critical path is the 8-bit setting times
// unit product feeding the tick compare; the skid register holds one result, and
// in_ready drops only while both hold results
// rst_n is synchronous, active low: state, settings and configuration take reset values
// cfg_ready is always high; writes to indexes past the last register are dropped
module watchdog_power_controller_unit #(
  parameter int TICK_BITS    = 32,
  parameter int SETTING_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // tick items
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_button_pressed,
  input  logic                    in_host_write,
  input  logic [SETTING_BITS-1:0] in_new_watchdog,
  input  logic [SETTING_BITS-1:0] in_new_reboot,
  input  logic                    in_host_read,
  input  logic                    in_clear_status,
  // results
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_power_on,
  output logic                    out_led_on,
  output logic [2:0]              out_status_bits,
  output logic [SETTING_BITS-1:0] out_watchdog_value,
  output logic [SETTING_BITS-1:0] out_reboot_value,
  output logic [2:0]              out_mode,
  // configuration writes
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [2:0]              cfg_index,
  input  logic [15:0]             cfg_data
);

  // product of a setting and an 8-bit unit, and the width both sides are compared at
  localparam int LIM_W = SETTING_BITS + 8;
  localparam int CMP_W = (LIM_W > TICK_BITS) ? LIM_W : TICK_BITS;

  typedef struct packed {
    logic                    power_on;
    logic                    led_on;
    logic [2:0]              status_bits;
    logic [SETTING_BITS-1:0] watchdog_value;
    logic [SETTING_BITS-1:0] reboot_value;
    logic [2:0]              mode;
  } result_t;

  // configuration
  logic [15:0] long_press_r;
  logic [7:0]  wd_unit_r;
  logic [7:0]  reboot_unit_r;
  logic [7:0]  wake_hold_r;
  logic [7:0]  blink_half_r;

  // controller state
  wpc_pkg::mode_t          mode_r, mode_nxt;
  logic [TICK_BITS-1:0]    tick_r, tick_nxt;
  logic [TICK_BITS-1:0]    press_start_r, press_start_nxt;
  logic [TICK_BITS-1:0]    act_start_r, act_start_nxt;
  logic [TICK_BITS-1:0]    reboot_start_r, reboot_start_nxt;
  logic [SETTING_BITS-1:0] wd_set_r, wd_set_nxt;
  logic [SETTING_BITS-1:0] rb_set_r, rb_set_nxt;
  logic [2:0]              status_r, status_nxt;
  logic                    led_r, led_nxt;
  logic [7:0]              delay_r, delay_nxt;
  logic                    boot_btn_r, boot_btn_nxt;

  // output register and skid stage
  result_t out_r, skid_r, result;
  logic    out_valid_r, skid_valid_r;

  logic accept;
  logic btn;

  // shared decision terms
  logic [TICK_BITS-1:0]    now;
  logic [TICK_BITS-1:0]    held;
  logic                    held_long;
  logic                    went_long;
  logic [SETTING_BITS-1:0] wd_eff, rb_eff;
  logic [TICK_BITS-1:0]    act_run, act_chk;
  logic [TICK_BITS-1:0]    wd_idle;
  logic [LIM_W-1:0]        wd_limit;
  logic                    wd_fire;
  logic [TICK_BITS-1:0]    rb_elapsed;
  logic [LIM_W-1:0]        rb_wait;
  logic                    rb_done;
  logic                    blink_hit;
  logic                    hold_done;
  logic [7:0]              delay_bump;
  logic                    phase_lit;

  assign in_ready  = !skid_valid_r;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign btn       = in_button_pressed;

  assign now       = tick_r;
  assign tick_nxt  = tick_r + TICK_BITS'(1);
  assign held      = now - press_start_r;
  assign held_long = held > TICK_BITS'(long_press_r);
  assign went_long = (mode_r == wpc_pkg::MODE_PRESSED) && btn && held_long;

  // settings as seen after this tick's host write
  assign wd_eff  = in_host_write ? in_new_watchdog : wd_set_r;
  assign rb_eff  = in_host_write ? in_new_reboot   : rb_set_r;
  assign act_run = in_host_write ? now : act_start_r;
  assign act_chk = in_host_read  ? now : act_run;

  // tick differences wrap at the tick width before they are compared
  assign wd_idle  = now - act_chk;
  assign wd_limit = LIM_W'(wd_eff) * LIM_W'(wd_unit_r);
  assign wd_fire  = (wd_eff != '0) && (CMP_W'(wd_idle) > CMP_W'(wd_limit));

  assign rb_elapsed = now - reboot_start_r;
  assign rb_wait    = LIM_W'(rb_set_r) * LIM_W'(reboot_unit_r);
  assign rb_done    = CMP_W'(rb_elapsed) >= CMP_W'(rb_wait);

  assign blink_hit  = ({1'b0, delay_r} + 9'd1) >= {1'b0, blink_half_r};
  assign hold_done  = (delay_r >= wake_hold_r) && !btn;
  assign delay_bump = (delay_r == wpc_pkg::DELAY_MAX) ? delay_r : delay_r + 8'd1;
  assign phase_lit  = ((now[7:0] & wpc_pkg::LED_PHASE_MASK) == wpc_pkg::LED_PHASE_ON);

  // next mode
  always_comb begin
    mode_nxt = mode_r;
    unique case (mode_r)
      wpc_pkg::MODE_BLINK: begin
        if (!btn) mode_nxt = wpc_pkg::MODE_OFF;
      end
      wpc_pkg::MODE_OFF: begin
        if (btn) mode_nxt = wpc_pkg::MODE_OFF_HOLD;
      end
      wpc_pkg::MODE_OFF_HOLD, wpc_pkg::MODE_REBOOT_HOLD: begin
        if (hold_done) mode_nxt = wpc_pkg::MODE_RUN;
      end
      wpc_pkg::MODE_REBOOT: begin
        if (btn) mode_nxt = wpc_pkg::MODE_REBOOT_HOLD;
        else if (rb_done) mode_nxt = wpc_pkg::MODE_RUN;
      end
      default: begin
        // run, pressed, and the unused code handled as run
        if (mode_r == wpc_pkg::MODE_PRESSED) begin
          if (went_long) mode_nxt = wpc_pkg::MODE_BLINK;
          else if (!btn) mode_nxt = wpc_pkg::MODE_RUN;
        end else begin
          mode_nxt = btn ? wpc_pkg::MODE_PRESSED : wpc_pkg::MODE_RUN;
        end
        if (!went_long && wd_fire) begin
          mode_nxt = (rb_eff != '0) ? wpc_pkg::MODE_REBOOT : wpc_pkg::MODE_OFF;
        end
      end
    endcase
  end

  // next datapath state
  always_comb begin
    press_start_nxt  = press_start_r;
    act_start_nxt    = act_start_r;
    reboot_start_nxt = reboot_start_r;
    wd_set_nxt       = wd_set_r;
    rb_set_nxt       = rb_set_r;
    status_nxt       = status_r;
    led_nxt          = led_r;
    delay_nxt        = delay_r;
    boot_btn_nxt     = boot_btn_r;
    unique case (mode_r)
      wpc_pkg::MODE_BLINK: begin
        if (btn) begin
          if (blink_hit) begin
            led_nxt   = !led_r;
            delay_nxt = '0;
          end else begin
            delay_nxt = delay_bump;
          end
        end else begin
          led_nxt = 1'b0;
        end
      end
      wpc_pkg::MODE_OFF: begin
        led_nxt = 1'b0;
        if (btn) begin
          led_nxt      = 1'b1;
          delay_nxt    = '0;
          boot_btn_nxt = 1'b1;
        end
      end
      wpc_pkg::MODE_OFF_HOLD, wpc_pkg::MODE_REBOOT_HOLD: begin
        if (hold_done) begin
          wd_set_nxt = '0;
          rb_set_nxt = '0;
          status_nxt = boot_btn_r ? wpc_pkg::ST_BUTTON : wpc_pkg::ST_TIMER;
        end else begin
          delay_nxt = delay_bump;
        end
      end
      wpc_pkg::MODE_REBOOT: begin
        if (btn) begin
          led_nxt      = 1'b1;
          wd_set_nxt   = '0;
          rb_set_nxt   = '0;
          delay_nxt    = '0;
          boot_btn_nxt = 1'b1;
        end else if (rb_done) begin
          led_nxt      = 1'b1;
          wd_set_nxt   = '0;
          rb_set_nxt   = '0;
          boot_btn_nxt = 1'b0;
          status_nxt   = wpc_pkg::ST_TIMER;
        end else begin
          led_nxt = phase_lit;
        end
      end
      default: begin
        if (in_host_write) begin
          wd_set_nxt    = in_new_watchdog;
          rb_set_nxt    = in_new_reboot;
          act_start_nxt = now;
          if (in_clear_status) status_nxt = '0;
        end
        if (mode_r == wpc_pkg::MODE_PRESSED) begin
          if (went_long) begin
            led_nxt   = !led_r;
            delay_nxt = '0;
          end else if (!btn) begin
            status_nxt = status_nxt | wpc_pkg::ST_SHORT;
          end
        end else if (btn) begin
          press_start_nxt = now;
        end
        if (!went_long && (wd_eff != '0)) begin
          act_start_nxt = act_chk;
          if (wd_fire) begin
            if (rb_eff != '0) reboot_start_nxt = now;
            else led_nxt = 1'b0;
          end
        end
      end
    endcase
  end

  // result after this tick
  always_comb begin
    result.power_on       = !((mode_nxt == wpc_pkg::MODE_OFF) ||
                              (mode_nxt == wpc_pkg::MODE_OFF_HOLD) ||
                              (mode_nxt == wpc_pkg::MODE_REBOOT));
    result.led_on         = led_nxt;
    result.status_bits    = status_nxt;
    result.watchdog_value = wd_set_nxt;
    result.reboot_value   = rb_set_nxt;
    result.mode           = mode_nxt;
  end

  // state advances once per accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= wpc_pkg::MODE_RUN;
      tick_r         <= '0;
      press_start_r  <= '0;
      act_start_r    <= '0;
      reboot_start_r <= '0;
      wd_set_r       <= '0;
      rb_set_r       <= '0;
      status_r       <= '0;
      led_r          <= 1'b1;
      delay_r        <= '0;
      boot_btn_r     <= 1'b0;
    end else if (accept) begin
      mode_r         <= mode_nxt;
      tick_r         <= tick_nxt;
      press_start_r  <= press_start_nxt;
      act_start_r    <= act_start_nxt;
      reboot_start_r <= reboot_start_nxt;
      wd_set_r       <= wd_set_nxt;
      rb_set_r       <= rb_set_nxt;
      status_r       <= status_nxt;
      led_r          <= led_nxt;
      delay_r        <= delay_nxt;
      boot_btn_r     <= boot_btn_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_r  <= wpc_pkg::LONG_PRESS_RST;
      wd_unit_r     <= wpc_pkg::WD_UNIT_RST;
      reboot_unit_r <= wpc_pkg::REBOOT_UNIT_RST;
      wake_hold_r   <= wpc_pkg::WAKE_HOLD_RST;
      blink_half_r  <= wpc_pkg::BLINK_HALF_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        wpc_pkg::CFG_LONG_PRESS:  long_press_r  <= cfg_data;
        wpc_pkg::CFG_WD_UNIT:     wd_unit_r     <= cfg_data[7:0];
        wpc_pkg::CFG_REBOOT_UNIT: reboot_unit_r <= cfg_data[7:0];
        wpc_pkg::CFG_WAKE_HOLD:   wake_hold_r   <= cfg_data[7:0];
        wpc_pkg::CFG_BLINK_HALF:  blink_half_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // output register with skid behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_valid_r && !out_ready) begin
      // output stalled: a new result waits in the skid stage
      if (accept) skid_valid_r <= 1'b1;
    end else if (skid_valid_r) begin
      out_valid_r  <= 1'b1;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_r && !out_ready) begin
      if (accept) skid_r <= result;
    end else if (skid_valid_r) begin
      out_r <= skid_r;
    end else if (accept) begin
      out_r <= result;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_power_on       = out_r.power_on;
  assign out_led_on         = out_r.led_on;
  assign out_status_bits    = out_r.status_bits;
  assign out_watchdog_value = out_r.watchdog_value;
  assign out_reboot_value   = out_r.reboot_value;
  assign out_mode           = out_r.mode;

endmodule

// File: hdl/wpc_checker.sv
module wpc_checker #(
  parameter int SETTING_BITS = 8
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic                    out_power_on,
  input logic                    out_led_on,
  input logic [2:0]              out_status_bits,
  input logic [SETTING_BITS-1:0] out_watchdog_value,
  input logic [SETTING_BITS-1:0] out_reboot_value,
  input logic [2:0]              out_mode
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mode) &&
      $stable(out_status_bits) && $stable(out_led_on) && $stable(out_power_on) &&
      $stable(out_watchdog_value) && $stable(out_reboot_value))
    else $error("stalled result changed");

  // a request taken while the output drains shows up next cycle
  a_accept_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (!out_valid || out_ready) |=> out_valid)
    else $error("accepted request produced no result");

  // back-pressure only with a result pending
  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("in_ready low with empty output");

  // off mode means supply cut and led dark
  a_off_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_mode == wpc_pkg::MODE_OFF) |-> !out_power_on && !out_led_on)
    else $error("off mode with power or led on");

endmodule

bind watchdog_power_controller_unit wpc_checker #(.SETTING_BITS(SETTING_BITS)) u_wpc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_power_on      (out_power_on),
  .out_led_on        (out_led_on),
  .out_status_bits   (out_status_bits),
  .out_watchdog_value(out_watchdog_value),
  .out_reboot_value  (out_reboot_value),
  .out_mode          (out_mode)
);

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int HANG_LIMIT = 4000;  // cycles with no handshake on any channel

  // one tick request as driven on the in_ channel
  typedef struct packed {
    logic       button;
    logic       host_wr;
    logic [7:0] new_wd;
    logic [7:0] new_rb;
    logic       host_rd;
    logic       clr;
  } tick_item_t;

  // one result as seen on the out_ channel
  typedef struct packed {
    logic       power;
    logic       led;
    logic [2:0] status;
    logic [7:0] wd;
    logic [7:0] rb;
    logic [2:0] mode;
  } tick_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_button_pressed = 1'b0;
  logic       in_host_write = 1'b0;
  logic [7:0] in_new_watchdog = '0;
  logic [7:0] in_new_reboot = '0;
  logic       in_host_read = 1'b0;
  logic       in_clear_status = 1'b0;

  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_power_on;
  logic       out_led_on;
  logic [2:0] out_status_bits;
  logic [7:0] out_watchdog_value;
  logic [7:0] out_reboot_value;
  logic [2:0] out_mode;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // results still owed by the block, oldest first
  tick_result_t pending_results[$];

  int mismatches = 0;
  int items_sent = 0;
  int idle_pct = 0;   // chance per request that the sender pauses first
  int stall_pct = 0;  // chance per cycle that the receiver holds off

  // ---------------------------------------------------------------------------
  // shadow of the controller: timing registers and internal state
  // ---------------------------------------------------------------------------
  logic [15:0] long_press_cfg;
  logic [7:0]  wd_unit_cfg;
  logic [7:0]  rb_unit_cfg;
  logic [7:0]  wake_hold_cfg;
  logic [7:0]  blink_half_cfg;

  logic [31:0] tick_cnt;
  logic [31:0] press_t0;
  logic [31:0] activity_t0;
  logic [31:0] reboot_t0;
  logic [7:0]  wd_setting;
  logic [7:0]  rb_setting;
  logic [2:0]  status_q;
  logic        led_q;
  logic [7:0]  hold_cnt;
  logic        woke_by_button;
  wpc_pkg::mode_t mode_q;

  watchdog_power_controller_unit uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_button_pressed  (in_button_pressed),
    .in_host_write      (in_host_write),
    .in_new_watchdog    (in_new_watchdog),
    .in_new_reboot      (in_new_reboot),
    .in_host_read       (in_host_read),
    .in_clear_status    (in_clear_status),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_power_on       (out_power_on),
    .out_led_on         (out_led_on),
    .out_status_bits    (out_status_bits),
    .out_watchdog_value (out_watchdog_value),
    .out_reboot_value   (out_reboot_value),
    .out_mode           (out_mode),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void reset_power_model();
    long_press_cfg = wpc_pkg::LONG_PRESS_RST;
    wd_unit_cfg    = wpc_pkg::WD_UNIT_RST;
    rb_unit_cfg    = wpc_pkg::REBOOT_UNIT_RST;
    wake_hold_cfg  = wpc_pkg::WAKE_HOLD_RST;
    blink_half_cfg = wpc_pkg::BLINK_HALF_RST;
    tick_cnt       = '0;
    press_t0       = '0;
    activity_t0    = '0;
    reboot_t0      = '0;
    wd_setting     = '0;
    rb_setting     = '0;
    status_q       = '0;
    led_q          = 1'b1;
    hold_cnt       = '0;
    woke_by_button = 1'b0;
    mode_q         = wpc_pkg::MODE_RUN;
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [15:0] data);
    case (idx)
      wpc_pkg::CFG_LONG_PRESS:  long_press_cfg = data;
      wpc_pkg::CFG_WD_UNIT:     wd_unit_cfg    = data[7:0];
      wpc_pkg::CFG_REBOOT_UNIT: rb_unit_cfg    = data[7:0];
      wpc_pkg::CFG_WAKE_HOLD:   wake_hold_cfg  = data[7:0];
      wpc_pkg::CFG_BLINK_HALF:  blink_half_cfg = data[7:0];
      default: ;
    endcase
  endfunction

  // hold counter sticks at its top value
  function automatic void bump_hold();
    if (hold_cnt != wpc_pkg::DELAY_MAX) hold_cnt = hold_cnt + 8'd1;
  endfunction

  function automatic void clear_settings();
    wd_setting = '0;
    rb_setting = '0;
  endfunction

  // advance the shadow by one tick and return what the block should show
  function automatic tick_result_t advance_tick(tick_item_t it);
    logic [31:0]  now;
    logic [31:0]  wd_limit;
    logic [31:0]  rb_wait;
    logic         went_long;
    tick_result_t r;
    now = tick_cnt;
    went_long = 1'b0;
    case (mode_q)
      wpc_pkg::MODE_BLINK: begin
        if (it.button) begin
          // led flips every blink_half ticks, a zero setting flips every tick
          if (int'(hold_cnt) + 1 >= int'(blink_half_cfg)) begin
            led_q = ~led_q;
            hold_cnt = '0;
          end else begin
            bump_hold();
          end
        end else begin
          led_q = 1'b0;
          mode_q = wpc_pkg::MODE_OFF;
        end
      end
      wpc_pkg::MODE_OFF: begin
        led_q = 1'b0;
        if (it.button) begin
          led_q = 1'b1;
          hold_cnt = '0;
          woke_by_button = 1'b1;
          mode_q = wpc_pkg::MODE_OFF_HOLD;
        end
      end
      wpc_pkg::MODE_OFF_HOLD, wpc_pkg::MODE_REBOOT_HOLD: begin
        if (hold_cnt >= wake_hold_cfg && !it.button) begin
          clear_settings();
          status_q = woke_by_button ? wpc_pkg::ST_BUTTON : wpc_pkg::ST_TIMER;
          mode_q = wpc_pkg::MODE_RUN;
        end else begin
          bump_hold();
        end
      end
      wpc_pkg::MODE_REBOOT: begin
        rb_wait = 32'(rb_setting) * 32'(rb_unit_cfg);
        if (it.button) begin
          led_q = 1'b1;
          clear_settings();
          hold_cnt = '0;
          woke_by_button = 1'b1;
          mode_q = wpc_pkg::MODE_REBOOT_HOLD;
        end else if (now - reboot_t0 >= rb_wait) begin
          led_q = 1'b1;
          clear_settings();
          woke_by_button = 1'b0;
          status_q = wpc_pkg::ST_TIMER;
          mode_q = wpc_pkg::MODE_RUN;
        end else begin
          led_q = ((now[7:0] & wpc_pkg::LED_PHASE_MASK) == wpc_pkg::LED_PHASE_ON);
        end
      end
      default: begin
        // host traffic only counts in run and pressed
        if (it.host_wr) begin
          wd_setting = it.new_wd;
          rb_setting = it.new_rb;
          if (it.clr) status_q = '0;
          activity_t0 = now;
        end
        if (mode_q == wpc_pkg::MODE_PRESSED) begin
          if (it.button) begin
            if (now - press_t0 > 32'(long_press_cfg)) begin
              led_q = ~led_q;
              hold_cnt = '0;
              mode_q = wpc_pkg::MODE_BLINK;
              went_long = 1'b1;
            end
          end else begin
            status_q = status_q | wpc_pkg::ST_SHORT;
            mode_q = wpc_pkg::MODE_RUN;
          end
        end else begin
          mode_q = wpc_pkg::MODE_RUN;
          if (it.button) begin
            press_t0 = now;
            mode_q = wpc_pkg::MODE_PRESSED;
          end
        end
        // watchdog is skipped on the tick a long press starts
        if (!went_long && wd_setting != '0) begin
          wd_limit = 32'(wd_setting) * 32'(wd_unit_cfg);
          if (it.host_rd) activity_t0 = now;
          if (now - activity_t0 > wd_limit) begin
            if (rb_setting != '0) begin
              reboot_t0 = now;
              mode_q = wpc_pkg::MODE_REBOOT;
            end else begin
              led_q = 1'b0;
              mode_q = wpc_pkg::MODE_OFF;
            end
          end
        end
      end
    endcase
    tick_cnt = now + 32'd1;
    r.power  = !(mode_q == wpc_pkg::MODE_OFF || mode_q == wpc_pkg::MODE_OFF_HOLD ||
                 mode_q == wpc_pkg::MODE_REBOOT);
    r.led    = led_q;
    r.status = status_q;
    r.wd     = wd_setting;
    r.rb     = rb_setting;
    r.mode   = mode_q;
    return r;
  endfunction

  function automatic logic coin(int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  // mostly small settings so the watchdog fires within a few dozen ticks
  function automatic logic [7:0] rand_setting();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return 8'($urandom_range(1, 4));
    if (pick < 85) return '0;
    return rand_byte();
  endfunction

  // ---------------------------------------------------------------------------
  // request driving
  // ---------------------------------------------------------------------------

  // one tick request; valid stays high on return so back-to-back requests
  // need no gap, callers lower it before doing anything that takes time
  task automatic send_tick(input logic btn, input logic hw, input logic [7:0] nwd,
                           input logic [7:0] nrb, input logic hr, input logic clr);
    tick_item_t it;
    it = '{button: btn, host_wr: hw, new_wd: nwd, new_rb: nrb, host_rd: hr, clr: clr};
    while (coin(idle_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_button_pressed <= btn;
    in_host_write     <= hw;
    in_new_watchdog   <= nwd;
    in_new_reboot     <= nrb;
    in_host_read      <= hr;
    in_clear_status   <= clr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // request taken at this edge: fold it into the shadow
    pending_results.push_back(advance_tick(it));
    items_sent++;
  endtask

  // stop sending and let every owed result come back
  task automatic await_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, data);
  endtask

  // all five timing registers, written back to back while the block is idle
  task automatic set_timing(input logic [15:0] lp, input logic [7:0] wu, input logic [7:0] ru,
                            input logic [7:0] wh, input logic [7:0] bh);
    cfg_write(wpc_pkg::CFG_LONG_PRESS, lp);
    cfg_write(wpc_pkg::CFG_WD_UNIT, {8'd0, wu});
    cfg_write(wpc_pkg::CFG_REBOOT_UNIT, {8'd0, ru});
    cfg_write(wpc_pkg::CFG_WAKE_HOLD, {8'd0, wh});
    cfg_write(wpc_pkg::CFG_BLINK_HALF, {8'd0, bh});
    cfg_valid <= 1'b0;
  endtask

  // ticks with no host traffic and the button up
  task automatic quiet_ticks(input int n);
    repeat (n) send_tick(1'b0, 1'b0, rand_byte(), rand_byte(), 1'b0, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // random traffic building blocks
  // ---------------------------------------------------------------------------

  task automatic short_press();
    int hold;
    hold = $urandom_range(1, long_press_cfg < 16'd30 ? int'(long_press_cfg) : 30);
    repeat (hold) send_tick(1'b1, 1'b0, rand_byte(), rand_byte(), coin(20), 1'b0);
    send_tick(1'b0, 1'b0, rand_byte(), rand_byte(), coin(20), 1'b0);
  endtask

  // held past the threshold, blinks, then powers off on release; above 40 it is a short press
  task automatic long_press();
    int hold;
    if (long_press_cfg > 16'd40) begin
      short_press();
    end else begin
      hold = int'(long_press_cfg) + 2 + $urandom_range(0, 2 * int'(blink_half_cfg) + 2);
      repeat (hold) send_tick(1'b1, 1'b0, rand_byte(), rand_byte(), coin(10), 1'b0);
      send_tick(1'b0, 1'b0, rand_byte(), rand_byte(), 1'b0, 1'b0);
    end
  endtask

  // press to wake from off, then release until back in run
  task automatic wake_up();
    int hold;
    int guard;
    hold = $urandom_range(1, wake_hold_cfg < 8'd18 ? int'(wake_hold_cfg) + 2 : 20);
    repeat (hold) send_tick(1'b1, coin(10), rand_byte(), rand_byte(), coin(10), 1'b0);
    guard = 0;
    while (mode_q != wpc_pkg::MODE_RUN && guard < 300) begin
      send_tick(1'b0, coin(10), rand_byte(), rand_byte(), coin(10), coin(50));
      guard++;
    end
  endtask

  task automatic host_update();
    send_tick(1'b0, 1'b1, rand_setting(), rand_setting(), coin(30), coin(50));
  endtask

  task automatic host_reads();
    repeat ($urandom_range(1, 10))
      send_tick(1'b0, 1'b0, rand_byte(), rand_byte(), coin(50), 1'b0);
  endtask

  // every field random, button included
  task automatic noise_burst();
    repeat ($urandom_range(1, 4))
      send_tick(coin(50), coin(50), rand_byte(), rand_byte(), coin(50), coin(50));
  endtask

  // press and host sequences with some noise bursts, steered by the shadow's mode
  task automatic random_segment(input int n);
    int stop_at;
    int pick;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (mode_q == wpc_pkg::MODE_OFF || mode_q == wpc_pkg::MODE_OFF_HOLD ||
          mode_q == wpc_pkg::MODE_REBOOT_HOLD) begin
        if (pick < 85) wake_up();
        else noise_burst();
      end else if (pick < 25) begin
        short_press();
      end else if (pick < 35) begin
        long_press();
      end else if (pick < 55) begin
        host_update();
      end else if (pick < 65) begin
        host_reads();
      end else if (pick < 88) begin
        // can be long enough for the watchdog to run out
        quiet_ticks($urandom_range(3, 50));
      end else begin
        noise_burst();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset timing: settings at both extremes, a short press, status clear
  task automatic test_host_settings();
    quiet_ticks(1);
    send_tick(1'b0, 1'b1, 8'hFF, 8'hFF, 1'b1, 1'b1);
    send_tick(1'b1, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 8'h00, 8'h00, 1'b0, 1'b1);
    await_results();
  endtask

  // long press at threshold 1, blink toggling every tick, off, then wake with no holdoff
  task automatic test_long_press_and_wake();
    set_timing(16'd1, 8'd0, 8'd0, 8'd0, 8'd0);
    repeat (4) send_tick(1'b1, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0);
    quiet_ticks(1);
    send_tick(1'b1, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0);
  endtask

  // zero unit registers: watchdog fires a tick after activity, reboot ends at once
  task automatic test_zero_units();
    send_tick(1'b0, 1'b1, 8'd1, 8'd1, 1'b0, 1'b0);
    quiet_ticks(2);
    // reboot value zero turns a timeout into shutdown
    send_tick(1'b0, 1'b1, 8'd1, 8'd0, 1'b0, 1'b0);
    quiet_ticks(1);
    send_tick(1'b1, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0);
    await_results();
  endtask

  // long reboot ended by a press, then the reboot holdoff runs out
  task automatic test_reboot_cut_short();
    set_timing(16'd2, 8'd1, 8'hFF, 8'd3, 8'd2);
    send_tick(1'b0, 1'b1, 8'd1, 8'd1, 1'b0, 1'b0);
    quiet_ticks(3);
    send_tick(1'b1, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0);
    repeat (5) send_tick(1'b0, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0);
    await_results();
  endtask

  task automatic test_random_traffic(input int idle, input int stall, input int n);
    idle_pct  = idle;
    stall_pct = stall;
    set_timing(16'($urandom_range(1, 24)), 8'($urandom_range(1, 6)),
               8'($urandom_range(1, 8)), 8'($urandom_range(0, 8)),
               8'($urandom_range(1, 5)));
    random_segment(n);
    await_results();
  endtask

  // every timing register at its top value
  task automatic test_config_limits();
    idle_pct  = 23;
    stall_pct = 23;
    set_timing(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    random_segment(60);
    await_results();
  endtask

  // ---------------------------------------------------------------------------
  // receiver and result check
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    out_ready <= !coin(stall_pct);
  end

  always @(posedge clk) begin : result_check
    tick_result_t got;
    tick_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{power: out_power_on, led: out_led_on, status: out_status_bits,
              wd: out_watchdog_value, rb: out_reboot_value, mode: out_mode};
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result with no request outstanding: %s",
                   $time, $sformatf("pwr=%b led=%b st=%b wd=%h rb=%h mode=%0d",
                   got.power, got.led, got.status, got.wd, got.rb, got.mode));
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          if (mismatches < 10)
            $display("%0t: mismatch exp %s | got %s", $time,
                     $sformatf("pwr=%b led=%b st=%b wd=%h rb=%h mode=%0d",
                               want.power, want.led, want.status, want.wd, want.rb,
                               want.mode),
                     $sformatf("pwr=%b led=%b st=%b wd=%h rb=%h mode=%0d",
                               got.power, got.led, got.status, got.wd, got.rb,
                               got.mode));
          mismatches++;
        end
      end
    end
  end

  // hang guard: any handshake resets the count
  initial begin : hang_guard
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < HANG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // sequence of tests
  // ---------------------------------------------------------------------------
  initial begin
    reset_power_model();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_host_settings();
    test_long_press_and_wake();
    test_zero_units();
    test_reboot_cut_short();

    // idling mixes: none, sender sparse, receiver stalling, both
    test_random_traffic(0, 0, 170);
    test_random_traffic(79, 0, 170);
    test_random_traffic(0, 79, 170);
    test_random_traffic(23, 23, 170);
    test_config_limits();

    // drained: give a stray result the chance to show up
    repeat (16) @(posedge clk);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
